// ===== rtl/intel_hex_word_loader_assert.svh =====
// assertion macros for the hex loader
`ifndef INTEL_HEX_WORD_LOADER_ASSERT_SVH
`define INTEL_HEX_WORD_LOADER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define IHWL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihwl assertion failed");

// antecedent implies consequent in the next cycle
`define IHWL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ihwl assertion failed");

`else

`define IHWL_ASSERT_SAME(label, clk, rst, ante, cons)
`define IHWL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ihwl_pkg.sv =====
package ihwl_pkg;

   // parse step codes
   localparam logic [5:0] STEP_IDLE       = 6'd0;
   localparam logic [5:0] STEP_COUNT_HI   = 6'd1;
   localparam logic [5:0] STEP_COUNT_LO   = 6'd2;
   localparam logic [5:0] STEP_ADDR_FIRST = 6'd3;
   localparam logic [5:0] STEP_ADDR_LAST  = 6'd6;
   localparam logic [5:0] STEP_KIND_HI    = 6'd7;
   localparam logic [5:0] STEP_KIND_LO    = 6'd8;
   localparam logic [5:0] STEP_SEG4_FIRST = 6'd9;
   localparam logic [5:0] STEP_SEG4_LAST  = 6'd12;
   localparam logic [5:0] STEP_SEG4_APPLY = 6'd13;
   localparam logic [5:0] STEP_DATA_FIRST = 6'd14;
   localparam logic [5:0] STEP_DATA_LAST  = 6'd21;
   localparam logic [5:0] STEP_SEG16_FIRST = 6'd39;
   localparam logic [5:0] STEP_SEG16_LAST  = 6'd42;
   localparam logic [5:0] STEP_SEG16_APPLY = 6'd43;

   // characters
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_GO_LOW  = 8'h67;
   localparam logic [7:0] CHAR_GO_UP   = 8'h47;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] LETTER_SKIP  = 8'd7;

   // record types
   localparam logic [7:0] REC_DATA  = 8'h00;
   localparam logic [7:0] REC_END   = 8'h01;
   localparam logic [7:0] REC_SEG4  = 8'h02;
   localparam logic [7:0] REC_SEG16 = 8'h04;

   // response kinds
   localparam logic [1:0] KIND_WORD = 2'd0;
   localparam logic [1:0] KIND_SUM  = 2'd1;
   localparam logic [1:0] KIND_GO   = 2'd2;

   localparam logic [31:0] ADDR_STEP = 32'd4;

   typedef struct packed {
      logic [5:0]  parse_step;
      logic [7:0]  count_byte;
      logic [31:0] load_address;
      logic [7:0]  kind_byte;
      logic [31:0] segment_base;
      logic [31:0] word_shift;
      logic [31:0] sum_acc;
      logic [31:0] min_addr;
      logic [31:0] max_addr;
      logic        halted;
   } parse_state_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] word_address;
      logic [31:0] word_data;
      logic [31:0] running_sum;
      logic [31:0] lowest_address;
      logic [31:0] highest_address;
   } rsp_payload_type;

   localparam parse_state_type STATE_RESET = '{
      parse_step:   STEP_IDLE,
      count_byte:   8'h00,
      load_address: 32'h0,
      kind_byte:    8'h00,
      segment_base: 32'h0,
      word_shift:   32'h0,
      sum_acc:      32'h0,
      min_addr:     32'hFFFF_FFFF,
      max_addr:     32'h0,
      halted:       1'b0
   };

   // ascii hex digit to nibble, letters folded down by seven
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] adj;
      adj = (c > CHAR_NINE) ? (c - LETTER_SKIP) : c;
      return adj[3:0];
   endfunction

   function automatic logic [31:0] byte_swap(input logic [31:0] d);
      return {d[7:0], d[15:8], d[23:16], d[31:24]};
   endfunction

endpackage

// ===== rtl/ihwl_chan_if.sv =====
interface ihwl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_char;

   modport source (output valid, output rx_char, input ready);
   modport sink (input valid, input rx_char, output ready);
endinterface

interface ihwl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] word_address;
   logic [31:0] word_data;
   logic [31:0] running_sum;
   logic [31:0] lowest_address;
   logic [31:0] highest_address;

   modport source (output valid, output result_kind, output word_address,
                   output word_data, output running_sum, output lowest_address,
                   output highest_address, input ready);
   modport sink (input valid, input result_kind, input word_address,
                 input word_data, input running_sum, input lowest_address,
                 input highest_address, output ready);
endinterface

// ===== rtl/ihwl_step.sv =====
// one character through the record parser
module ihwl_step (
   input  ihwl_pkg::parse_state_type state_cur,
   input  logic [7:0]                rx_char,
   output ihwl_pkg::parse_state_type state_nxt,
   output logic                      res_valid,
   output ihwl_pkg::rsp_payload_type res
);

   logic [3:0]  nib;
   logic [7:0]  kind_new;
   logic [31:0] shift_new;
   logic [31:0] swapped;
   logic [5:0]  s;

   assign nib       = ihwl_pkg::hex_nibble(rx_char);
   assign s         = state_cur.parse_step;
   assign kind_new  = {state_cur.kind_byte[3:0], nib};
   assign shift_new = {state_cur.word_shift[27:0], nib};
   assign swapped   = ihwl_pkg::byte_swap(shift_new);

   always_comb begin
      state_nxt = state_cur;
      res_valid = 1'b0;
      res       = '0;
      if (state_cur.halted) begin
         state_nxt = state_cur;
      end else if (rx_char == ihwl_pkg::CHAR_COLON) begin
         state_nxt.parse_step = ihwl_pkg::STEP_COUNT_HI;
      end else if (rx_char == ihwl_pkg::CHAR_CR || rx_char == ihwl_pkg::CHAR_LF) begin
         state_nxt.parse_step = ihwl_pkg::STEP_IDLE;
      end else if (rx_char == ihwl_pkg::CHAR_GO_LOW || rx_char == ihwl_pkg::CHAR_GO_UP) begin
         state_nxt.parse_step = ihwl_pkg::STEP_IDLE;
         state_nxt.halted     = 1'b1;
         res_valid            = 1'b1;
         res.result_kind      = ihwl_pkg::KIND_GO;
         res.lowest_address   = state_cur.min_addr;
         res.highest_address  = state_cur.max_addr;
      end else if (s == ihwl_pkg::STEP_COUNT_HI || s == ihwl_pkg::STEP_COUNT_LO) begin
         state_nxt.count_byte = {state_cur.count_byte[3:0], nib};
         state_nxt.parse_step = s + 6'd1;
      end else if (s >= ihwl_pkg::STEP_ADDR_FIRST && s <= ihwl_pkg::STEP_ADDR_LAST) begin
         state_nxt.load_address = {16'h0, state_cur.load_address[11:0], nib}
                                  | state_cur.segment_base;
         state_nxt.parse_step = s + 6'd1;
      end else if (s == ihwl_pkg::STEP_KIND_HI) begin
         state_nxt.kind_byte  = kind_new;
         state_nxt.parse_step = ihwl_pkg::STEP_KIND_LO;
      end else if (s == ihwl_pkg::STEP_KIND_LO) begin
         state_nxt.kind_byte = kind_new;
         case (kind_new)
            ihwl_pkg::REC_DATA: begin
               state_nxt.parse_step = ihwl_pkg::STEP_DATA_FIRST;
            end
            ihwl_pkg::REC_END: begin
               state_nxt.parse_step = ihwl_pkg::STEP_IDLE;
               res_valid            = 1'b1;
               res.result_kind      = ihwl_pkg::KIND_SUM;
               res.running_sum      = state_cur.sum_acc;
            end
            ihwl_pkg::REC_SEG4: begin
               state_nxt.parse_step = ihwl_pkg::STEP_SEG4_FIRST;
            end
            ihwl_pkg::REC_SEG16: begin
               state_nxt.parse_step = ihwl_pkg::STEP_SEG16_FIRST;
            end
            default: begin
               state_nxt.parse_step = ihwl_pkg::STEP_IDLE;
            end
         endcase
      end else if ((s >= ihwl_pkg::STEP_SEG4_FIRST && s <= ihwl_pkg::STEP_SEG4_LAST) ||
                   (s >= ihwl_pkg::STEP_SEG16_FIRST && s <= ihwl_pkg::STEP_SEG16_LAST)) begin
         state_nxt.segment_base = {16'h0, state_cur.segment_base[11:0], nib};
         state_nxt.parse_step   = s + 6'd1;
      end else if (s == ihwl_pkg::STEP_SEG4_APPLY) begin
         state_nxt.segment_base = {state_cur.segment_base[27:0], 4'h0};
         state_nxt.parse_step   = ihwl_pkg::STEP_IDLE;
      end else if (s == ihwl_pkg::STEP_SEG16_APPLY) begin
         state_nxt.segment_base = {state_cur.segment_base[15:0], 16'h0};
         state_nxt.parse_step   = ihwl_pkg::STEP_IDLE;
      end else if (s >= ihwl_pkg::STEP_DATA_FIRST && s <= ihwl_pkg::STEP_DATA_LAST) begin
         if (s == ihwl_pkg::STEP_DATA_LAST) begin
            state_nxt.word_shift   = swapped;
            if (state_cur.load_address < state_cur.min_addr) begin
               state_nxt.min_addr = state_cur.load_address;
            end
            if (state_cur.load_address > state_cur.max_addr) begin
               state_nxt.max_addr = state_cur.load_address;
            end
            state_nxt.sum_acc      = state_cur.sum_acc + state_cur.load_address + swapped;
            state_nxt.load_address = state_cur.load_address + ihwl_pkg::ADDR_STEP;
            state_nxt.parse_step   = ihwl_pkg::STEP_DATA_FIRST;
            res_valid              = 1'b1;
            res.result_kind        = ihwl_pkg::KIND_WORD;
            res.word_address       = state_cur.load_address;
            res.word_data          = swapped;
         end else begin
            state_nxt.word_shift = shift_new;
            state_nxt.parse_step = s + 6'd1;
         end
      end
   end

endmodule

// ===== rtl/intel_hex_word_loader.sv =====
// intel hex word loader: takes the text of an intel hex file one character per
// request and turns data records into 32-bit word writes (bytes swapped, four
// bytes per word, address stepping by four from the record address ored with
// the current segment). an end record returns the running sum of addresses and
// data; a 'g' or 'G' returns the lowest and highest written addresses and then
// the loader ignores everything until reset. checksums are not verified, and
// any non-hex character inside a record decodes to some nibble without error.
// rate: one character per clock whether or not it produces a response, while
// no pending response is held back by the response channel. a character is
// held in the input register and its response (if any) is registered in the
// response register; the parser state updates as the character leaves the
// input register, which is what allows back-to-back characters.
`include "intel_hex_word_loader_assert.svh"

module intel_hex_word_loader (
   input logic        clock,
   input logic        reset,
   ihwl_req_if.sink   req_chan,
   ihwl_rsp_if.source rsp_chan
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;

   // parser state
   ihwl_pkg::parse_state_type state_ff, state_in, state_step;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   ihwl_pkg::rsp_payload_type rsp_ff, rsp_in, step_res;
   logic                      step_res_valid;

   // the response slot is free or being drained this cycle
   logic advance;
   logic req_fire;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   ihwl_step u_step (
      .state_cur (state_ff),
      .rx_char   (in_char_ff),
      .state_nxt (state_step),
      .res_valid (step_res_valid),
      .res       (step_res)
   );

   always_comb begin
      // input stage refills on a request, empties when its character moves on
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_char_in  = req_chan.rx_char;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // state moves only when the held character is consumed
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff && step_res_valid;
         if (in_valid_ff) begin
            state_in = state_step;
            rsp_in   = step_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ihwl_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.result_kind     = rsp_ff.result_kind;
   assign rsp_chan.word_address    = rsp_ff.word_address;
   assign rsp_chan.word_data       = rsp_ff.word_data;
   assign rsp_chan.running_sum     = rsp_ff.running_sum;
   assign rsp_chan.lowest_address  = rsp_ff.lowest_address;
   assign rsp_chan.highest_address = rsp_ff.highest_address;

   // once halted, stays halted until reset
   `IHWL_ASSERT_NEXT(a_halt_sticky, clock, reset, state_ff.halted, state_ff.halted)

   // a go response is always accompanied by the halted state
   `IHWL_ASSERT_SAME(a_go_halts, clock, reset,
      rsp_valid_ff && rsp_ff.result_kind == ihwl_pkg::KIND_GO, state_ff.halted)

   // a fresh response needs a character in the input register the cycle before
   `IHWL_ASSERT_SAME(a_rsp_from_char, clock, reset, $rose(rsp_valid_ff), $past(in_valid_ff))

   // after a word write the address bounds are ordered
   `IHWL_ASSERT_SAME(a_bounds_order, clock, reset,
      rsp_valid_ff && rsp_ff.result_kind == ihwl_pkg::KIND_WORD,
      state_ff.min_addr <= state_ff.max_addr)

endmodule
